FILE: hw/rtl/premultiplied_argb_blitter_unit_defines.svh
// ----------------------------------------------------------------------------
// Blitter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PREMULTIPLIED_ARGB_BLITTER_UNIT_DEFINES_SVH
`define PREMULTIPLIED_ARGB_BLITTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PAB_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define PAB_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: hw/rtl/pab_pkg.sv
// ----------------------------------------------------------------------------
// Blitter package
// Types, codes and sizing constants shared by the blitter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pab_pkg;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned MAX_PITCH    = 8191;
  localparam int unsigned COUNTER_BITS = 48;

  localparam int unsigned DIM_W   = 13;
  localparam int unsigned COL_W   = $clog2(MAX_DIM);
  localparam int unsigned OFF_W   = 25;
  localparam int unsigned AREA_W  = 2 * DIM_W;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_COPY  = 2'd1,
    MODE_BLEND = 2'd2
  } pab_mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_RECT_WIDTH  = 3'd1,
    REG_RECT_HEIGHT = 3'd2,
    REG_DEST_PITCH  = 3'd3,
    REG_SRC_PITCH   = 3'd4,
    REG_FILL_COLOR  = 3'd5,
    REG_PROFILE_EN  = 3'd6
  } pab_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_READ  = 1'b1
  } pab_op_e;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] source_pixel;
    logic [PIX_W-1:0] destination_pixel;
  } pab_in_t;

  typedef struct packed {
    logic                    write_enable;
    logic [OFF_W-1:0]        dest_offset;
    logic [OFF_W-1:0]        source_offset;
    logic [PIX_W-1:0]        out_pixel;
    logic                    last_pixel;
    logic [COUNTER_BITS-1:0] fill_count;
    logic [COUNTER_BITS-1:0] copy_count;
    logic [COUNTER_BITS-1:0] blend_count;
  } pab_out_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic [DIM_W-1:0] dest_pitch;
    logic [DIM_W-1:0] src_pitch;
    logic [PIX_W-1:0] fill_color;
    logic             profile_enable;
  } pab_cfg_t;

  typedef struct packed {
    logic             active;
    logic             last_pixel;
    logic [OFF_W-1:0] dest_offset;
    logic [OFF_W-1:0] source_offset;
  } pab_pos_t;

  typedef struct packed {
    logic [COUNTER_BITS-1:0] fill_count;
    logic [COUNTER_BITS-1:0] copy_count;
    logic [COUNTER_BITS-1:0] blend_count;
  } pab_counts_t;

endpackage

FILE: hw/rtl/premultiplied_argb_blitter_unit.sv
// ----------------------------------------------------------------------------
// Premultiplied ARGB blitter
// Items enter on a valid/ready channel carrying an operation and the source and
// destination pixels at the current raster position. Each accepted item gives
// exactly one result on the output valid/ready channel: destination and source
// offsets, the pixel to write, its write enable and the last-pixel flag, or,
// for a counter read, the three profile counts, which are then cleared.
// Registers are written through a plain write port (enable, index, data); the
// user must write them only while the block is idle, which the block itself
// does not enforce. A write to a geometry or mode register restarts the walk.
// An item is registered on the transfer, processed and written to the result
// register once that register is free. One item per cycle is sustained while
// the receiver takes results; the input register and the result register each
// hold one item, and the input register refills in the same cycle that it
// hands over. When the receiver stalls, the result register holds; one more
// item is held in the input register, after which ready falls.
// Reset clears valid flags, config, position and counters; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "premultiplied_argb_blitter_unit_defines.svh"

module premultiplied_argb_blitter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pab_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [pab_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pab_pkg::pab_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pab_pkg::pab_out_t         out_data_o
);

  pab_pkg::pab_cfg_t    cfg;
  logic                 restart;
  logic                 cfg_clear;
  pab_pkg::pab_pos_t    pos;
  pab_pkg::pab_counts_t counts;
  logic                 pix_we;
  logic [pab_pkg::PIX_W-1:0] pix;

  logic                 in_valid_q;
  pab_pkg::pab_in_t     in_data_q;
  logic                 out_valid_q;
  pab_pkg::pab_out_t    out_data_q, out_data_d;
  logic                 advance;
  logic                 is_read;
  logic                 step;
  logic                 wrap_step;
  logic                 at_origin;
  logic                 read_step;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign is_read    = in_data_q.operation == pab_pkg::OP_READ;
  assign step       = advance && !is_read;

  pab_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .restart_o   (restart),
    .clear_o     (cfg_clear)
  );

  pab_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .step_i    (step),
    .pos_o     (pos)
  );

  pab_pixel_op u_pixel (
    .mode_i         (cfg.mode),
    .fill_color_i   (cfg.fill_color),
    .src_i          (in_data_q.source_pixel),
    .dst_i          (in_data_q.destination_pixel),
    .write_enable_o (pix_we),
    .pixel_o        (pix)
  );

  pab_prof_counters u_counters (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_clear || (advance && is_read)),
    .add_i         (step && pos.active && pos.last_pixel && cfg.profile_enable),
    .mode_i        (cfg.mode),
    .rect_width_i  (cfg.rect_width),
    .rect_height_i (cfg.rect_height),
    .counts_o      (counts)
  );

  always_comb begin
    out_data_d = '0;
    if (is_read) begin
      out_data_d.fill_count  = counts.fill_count;
      out_data_d.copy_count  = counts.copy_count;
      out_data_d.blend_count = counts.blend_count;
    end else if (pos.active) begin
      out_data_d.write_enable  = pix_we;
      out_data_d.dest_offset   = pos.dest_offset;
      out_data_d.source_offset = pos.source_offset;
      out_data_d.out_pixel     = pix;
      out_data_d.last_pixel    = pos.last_pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign wrap_step = step && pos.active && pos.last_pixel;
  assign at_origin = (pos.dest_offset == '0) && (pos.source_offset == '0);
  assign read_step = advance && is_read;

  `PAB_ASSERT_NOW(a_ready_when_empty, !in_valid_q, in_ready_o, "input register empty, not ready")
  `PAB_ASSERT_NEXT(a_walk_wraps, wrap_step, at_origin, "walk not at origin after last pixel")
  `PAB_ASSERT_NEXT(a_read_clears, read_step, counts == '0, "counters not cleared by read")

endmodule

FILE: hw/rtl/pab_cfg_regs.sv
// ----------------------------------------------------------------------------
// Blitter configuration registers
// Holds the register file, saturates dimensions and flags restarts and clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pab_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pab_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [pab_pkg::CFG_W-1:0]        cfg_data_i,
  output pab_pkg::pab_cfg_t                cfg_o,
  output logic                             restart_o,
  output logic                             clear_o
);

  pab_pkg::pab_cfg_t              cfg_q, cfg_d;
  logic [pab_pkg::DIM_W-1:0]      raw;
  logic [pab_pkg::DIM_W-1:0]      dim_sat;
  logic [pab_pkg::DIM_W-1:0]      pitch_sat;

  assign raw       = cfg_data_i[pab_pkg::DIM_W-1:0];
  assign dim_sat   = (raw > pab_pkg::DIM_W'(pab_pkg::MAX_DIM)) ?
                     pab_pkg::DIM_W'(pab_pkg::MAX_DIM) : raw;
  assign pitch_sat = (raw > pab_pkg::DIM_W'(pab_pkg::MAX_PITCH)) ?
                     pab_pkg::DIM_W'(pab_pkg::MAX_PITCH) : raw;

  always_comb begin
    cfg_d     = cfg_q;
    restart_o = 1'b0;
    clear_o   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pab_pkg::REG_MODE: begin
          cfg_d.mode = cfg_data_i[1:0];
          restart_o  = 1'b1;
        end
        pab_pkg::REG_RECT_WIDTH: begin
          cfg_d.rect_width = dim_sat;
          restart_o        = 1'b1;
        end
        pab_pkg::REG_RECT_HEIGHT: begin
          cfg_d.rect_height = dim_sat;
          restart_o         = 1'b1;
        end
        pab_pkg::REG_DEST_PITCH: begin
          cfg_d.dest_pitch = pitch_sat;
          restart_o        = 1'b1;
        end
        pab_pkg::REG_SRC_PITCH: begin
          cfg_d.src_pitch = pitch_sat;
          restart_o       = 1'b1;
        end
        pab_pkg::REG_FILL_COLOR: begin
          cfg_d.fill_color = cfg_data_i[pab_pkg::PIX_W-1:0];
        end
        pab_pkg::REG_PROFILE_EN: begin
          cfg_d.profile_enable = cfg_data_i[0];
          clear_o              = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/pab_walker.sv
// ----------------------------------------------------------------------------
// Blitter raster walker
// Tracks row, column and row base offsets across the clipped rectangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pab_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pab_pkg::pab_cfg_t cfg_i,
  input  logic              restart_i,
  input  logic              step_i,
  output pab_pkg::pab_pos_t pos_o
);

  logic [pab_pkg::COL_W-1:0] column_q, column_d;
  logic [pab_pkg::COL_W-1:0] row_q, row_d;
  logic [pab_pkg::OFF_W-1:0] dest_row_base_q, dest_row_base_d;
  logic [pab_pkg::OFF_W-1:0] src_row_base_q, src_row_base_d;
  logic [pab_pkg::DIM_W-1:0] column_inc;
  logic [pab_pkg::DIM_W-1:0] row_inc;
  logic                      row_end;
  logic                      last;
  logic                      active;

  assign active     = (cfg_i.rect_width != '0) && (cfg_i.rect_height != '0);
  assign column_inc = {1'b0, column_q} + pab_pkg::DIM_W'(1);
  assign row_inc    = {1'b0, row_q} + pab_pkg::DIM_W'(1);
  assign row_end    = column_inc >= cfg_i.rect_width;
  assign last       = row_end && (row_inc >= cfg_i.rect_height);

  always_comb begin
    column_d        = column_q;
    row_d           = row_q;
    dest_row_base_d = dest_row_base_q;
    src_row_base_d  = src_row_base_q;
    if (restart_i) begin
      column_d        = '0;
      row_d           = '0;
      dest_row_base_d = '0;
      src_row_base_d  = '0;
    end else if (step_i && active) begin
      if (row_end) begin
        column_d = '0;
        if (last) begin
          row_d           = '0;
          dest_row_base_d = '0;
          src_row_base_d  = '0;
        end else begin
          row_d           = row_inc[pab_pkg::COL_W-1:0];
          dest_row_base_d = dest_row_base_q + pab_pkg::OFF_W'(cfg_i.dest_pitch);
          src_row_base_d  = src_row_base_q + pab_pkg::OFF_W'(cfg_i.src_pitch);
        end
      end else begin
        column_d = column_inc[pab_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q        <= '0;
      row_q           <= '0;
      dest_row_base_q <= '0;
      src_row_base_q  <= '0;
    end else begin
      column_q        <= column_d;
      row_q           <= row_d;
      dest_row_base_q <= dest_row_base_d;
      src_row_base_q  <= src_row_base_d;
    end
  end

  assign pos_o.active        = active;
  assign pos_o.last_pixel    = last;
  assign pos_o.dest_offset   = dest_row_base_q + pab_pkg::OFF_W'(column_q);
  assign pos_o.source_offset = src_row_base_q + pab_pkg::OFF_W'(column_q);

endmodule

FILE: hw/rtl/pab_pixel_op.sv
// ----------------------------------------------------------------------------
// Blitter pixel operation
// Fill, copy or premultiplied source-over blend of one ARGB8888 pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pab_pixel_op (
  input  logic [1:0]                mode_i,
  input  logic [pab_pkg::PIX_W-1:0] fill_color_i,
  input  logic [pab_pkg::PIX_W-1:0] src_i,
  input  logic [pab_pkg::PIX_W-1:0] dst_i,
  output logic                      write_enable_o,
  output logic [pab_pkg::PIX_W-1:0] pixel_o
);

  function automatic logic [7:0] scale_ch(logic [7:0] c, logic [7:0] inv);
    logic [15:0] t;
    logic [15:0] u;
    t = 16'(c) * 16'(inv) + 16'd128;
    u = t + {8'd0, t[15:8]};
    return u[15:8];
  endfunction

  logic [7:0]                alpha;
  logic [7:0]                inv;
  logic [pab_pkg::PIX_W-1:0] rb;
  logic [pab_pkg::PIX_W-1:0] ag;
  logic [pab_pkg::PIX_W-1:0] blended;

  assign alpha   = src_i[31:24];
  assign inv     = 8'hff - alpha;
  assign rb      = {8'd0, scale_ch(dst_i[23:16], inv), 8'd0, scale_ch(dst_i[7:0], inv)};
  assign ag      = {scale_ch(dst_i[31:24], inv), 8'd0, scale_ch(dst_i[15:8], inv), 8'd0};
  assign blended = src_i + rb + ag;

  always_comb begin
    write_enable_o = 1'b0;
    pixel_o        = '0;
    case (mode_i)
      pab_pkg::MODE_FILL: begin
        write_enable_o = 1'b1;
        pixel_o        = fill_color_i;
      end
      pab_pkg::MODE_COPY: begin
        write_enable_o = 1'b1;
        pixel_o        = src_i;
      end
      pab_pkg::MODE_BLEND: begin
        if (alpha == 8'hff) begin
          write_enable_o = 1'b1;
          pixel_o        = src_i;
        end else if (alpha == 8'h00) begin
          pixel_o = dst_i;
        end else begin
          write_enable_o = 1'b1;
          pixel_o        = blended;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/pab_prof_counters.sv
// ----------------------------------------------------------------------------
// Blitter profile counters
// Per-mode saturating pixel counters with clear on read or enable write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pab_prof_counters (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       add_i,
  input  logic [1:0]                 mode_i,
  input  logic [pab_pkg::DIM_W-1:0]  rect_width_i,
  input  logic [pab_pkg::DIM_W-1:0]  rect_height_i,
  output pab_pkg::pab_counts_t       counts_o
);

  localparam int unsigned CW = pab_pkg::COUNTER_BITS;

  pab_pkg::pab_counts_t       counts_q, counts_d;
  logic [pab_pkg::AREA_W-1:0] area;
  logic [CW-1:0]              base;
  logic [CW:0]                sum;
  logic [CW-1:0]              sat;

  assign area = pab_pkg::AREA_W'(rect_width_i) * pab_pkg::AREA_W'(rect_height_i);

  always_comb begin
    case (mode_i)
      pab_pkg::MODE_FILL:  base = counts_q.fill_count;
      pab_pkg::MODE_COPY:  base = counts_q.copy_count;
      default:             base = counts_q.blend_count;
    endcase
  end

  assign sum = {1'b0, base} + (CW + 1)'(area);
  assign sat = sum[CW] ? '1 : sum[CW-1:0];

  always_comb begin
    counts_d = counts_q;
    if (clear_i) begin
      counts_d = '0;
    end else if (add_i) begin
      case (mode_i)
        pab_pkg::MODE_FILL:  counts_d.fill_count  = sat;
        pab_pkg::MODE_COPY:  counts_d.copy_count  = sat;
        pab_pkg::MODE_BLEND: counts_d.blend_count = sat;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
    end else begin
      counts_q <= counts_d;
    end
  end

  assign counts_o = counts_q;

endmodule
